[rtl/sbce_pkg.sv]
// Shared types and constants for the segment box clip entry block.
`timescale 1ns / 1ps
package sbce_pkg;

	localparam int CoordW = 32;
	localparam int HalfW  = 31;
	localparam int WideW  = 34;
	localparam int EntryW = 17;
	localparam int NumEdges = 4;

	// per-edge flags that ride along with the divider lanes
	typedef struct packed {
		logic par;    // p is zero
		logic qneg;   // q below zero
		logic pneg;   // p below zero
		logic sdiff;  // p and q differ in sign
	} edge_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x0;
		logic signed [CoordW-1:0] y0;
		logic signed [WideW-1:0]  dx;
		logic signed [WideW-1:0]  dy;
		edge_t [NumEdges-1:0]     edges;
	} side_t;

endpackage

[rtl/sbce_in_if.sv]
// Input channel: one segment and one box per word.
`timescale 1ns / 1ps
interface sbce_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_x;
	logic [31:0] start_y;
	logic [31:0] end_x;
	logic [31:0] end_y;
	logic [31:0] box_center_x;
	logic [31:0] box_center_y;
	logic [30:0] box_half_width;
	logic [30:0] box_half_height;

	modport source (output valid, start_x, start_y, end_x, end_y, box_center_x,
		box_center_y, box_half_width, box_half_height, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, box_center_x,
		box_center_y, box_half_width, box_half_height, output ready);
endinterface

[rtl/sbce_out_if.sv]
// Output channel: hit flag, entry point and entry parameter per word.
`timescale 1ns / 1ps
interface sbce_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [16:0] entry_param;

	modport source (output valid, hit, point_x, point_y, entry_param, input ready);
	modport sink (input valid, hit, point_x, point_y, entry_param, output ready);
endinterface

[rtl/sbce_div.sv]
// Pipelined restoring divider: saturated quotient of (num << FB) / den, one bit per stage.
`timescale 1ns / 1ps
module sbce_div #(
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [33:0]   num,
	input  logic [33:0]   den,
	output logic [FB+1:0] quo
);
	localparam int QW = FB + 2;

	logic [33:0]   rem_s [QW];
	logic [33:0]   den_s [QW];
	logic [1:0]    low_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic          ovf_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [33:0]   rem_i;
		logic [33:0]   den_i;
		logic [1:0]    low_i;
		logic [QW-1:0] quo_i;
		logic          ovf_i;
		logic          bit_i;
		logic [34:0]   sh;
		logic [34:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i = {2'b00, num[33:2]};
			assign den_i = den;
			assign low_i = num[1:0];
			assign quo_i = '0;
			// quotient would need more than QW bits
			assign ovf_i = ({2'b00, num} >= {den, 2'b00});
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign low_i = low_s[k-1];
			assign quo_i = quo_s[k-1];
			assign ovf_i = ovf_s[k-1];
		end

		if (k == 0) begin : g_b0
			assign bit_i = low_i[1];
		end else if (k == 1) begin : g_b1
			assign bit_i = low_i[0];
		end else begin : g_bz
			assign bit_i = 1'b0;
		end

		assign sh   = {rem_i, bit_i};
		assign ge   = (sh >= {1'b0, den_i});
		assign diff = sh - {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[33:0] : sh[33:0];
				den_s[k] <= den_i;
				low_s[k] <= low_i;
				quo_s[k] <= {quo_i[QW-2:0], ge};
				ovf_s[k] <= ovf_i;
			end
		end
	end

	assign quo = ovf_s[QW-1] ? '1 : quo_s[QW-1];

endmodule

[rtl/sbce_point.sv]
// Edge combine, entry point multiply and saturating output register.
`timescale 1ns / 1ps
module sbce_point #(
	parameter int FB = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld,
	input  sbce_pkg::side_t side,
	input  logic [FB+1:0]  quo [sbce_pkg::NumEdges],
	output logic           en,
	sbce_out_if.source     out_ch
);
	localparam int QW = FB + 2;

	logic signed [QW:0] rv;
	logic signed [QW:0] t0c;
	logic signed [QW:0] t1c;
	logic               hitc;

	always_comb begin
		t0c  = '0;
		t1c  = '0;
		t1c[FB] = 1'b1;
		hitc = 1'b1;
		rv   = '0;
		for (int e = 0; e < sbce_pkg::NumEdges; e++) begin
			// any nonzero negative ratio reads as all ones, which compares below t0 and t1
			rv = (side.edges[e].sdiff && quo[e] != '0) ? '1 : {1'b0, quo[e]};
			if (hitc) begin
				if (side.edges[e].par) begin
					if (side.edges[e].qneg) hitc = 1'b0;
				end else if (side.edges[e].pneg) begin
					if (rv > t1c) hitc = 1'b0;
					else if (rv > t0c) t0c = rv;
				end else begin
					if (rv < t0c) hitc = 1'b0;
					else if (rv < t1c) t1c = rv;
				end
			end
		end
	end

	logic              vld_s1, vld_s2, vld_s3;
	logic              hit_s1, hit_s2, hit_s3;
	logic [FB:0]       t0_s1, t0_s2;
	logic signed [31:0] x0_s1, y0_s1, x0_s2, y0_s2;
	logic signed [33:0] dx_s1, dy_s1;
	logic signed [FB+35:0] px_s2, py_s2;
	logic signed [31:0] ptx_s3, pty_s3;
	logic [16:0]       ent_s3;

	assign en = !vld_s3 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// combine edges
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= hitc;
			t0_s1  <= t0c[FB:0];
			x0_s1  <= side.x0;
			y0_s1  <= side.y0;
			dx_s1  <= side.dx;
			dy_s1  <= side.dy;
		end
	end

	// offset along the segment
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2 <= hit_s1;
			t0_s2  <= t0_s1;
			x0_s2  <= x0_s1;
			y0_s2  <= y0_s1;
			px_s2  <= $signed({1'b0, t0_s1}) * dx_s1;
			py_s2  <= $signed({1'b0, t0_s1}) * dy_s1;
		end
	end

	logic signed [35:0] sx, sy;
	logic signed [31:0] satx, saty;
	logic [47:0]        tw;
	logic [16:0]        ent;

	// arithmetic shift by FB floors toward minus infinity
	assign sx = 36'(x0_s2) + px_s2[FB+35:FB];
	assign sy = 36'(y0_s2) + py_s2[FB+35:FB];
	assign tw = 48'(t0_s2);

	always_comb begin
		if (sx > 36'sd2147483647)        satx = 32'sh7fffffff;
		else if (sx < -36'sd2147483648)  satx = 32'sh80000000;
		else                             satx = sx[31:0];
		if (sy > 36'sd2147483647)        saty = 32'sh7fffffff;
		else if (sy < -36'sd2147483648)  saty = 32'sh80000000;
		else                             saty = sy[31:0];
	end

	if (FB >= 16) begin : g_down
		assign ent = tw[FB-16 +: 17];
	end else begin : g_up
		logic [47:0] tu;
		assign tu  = tw << (16 - FB);
		assign ent = tu[16:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= hit_s2;
			ptx_s3 <= hit_s2 ? satx : '0;
			pty_s3 <= hit_s2 ? saty : '0;
			ent_s3 <= hit_s2 ? ent : '0;
		end
	end

	assign out_ch.valid       = vld_s3;
	assign out_ch.hit         = hit_s3;
	assign out_ch.point_x     = ptx_s3;
	assign out_ch.point_y     = pty_s3;
	assign out_ch.entry_param = ent_s3;

endmodule

[rtl/segment_box_clip_entry.sv]
// Words pass stage 1, stage 2, the divider lanes and the sbce_point register stages.
// One word per cycle unless out_ch stalls; divider lanes have FRACTION_BITS + 2 stages.
// All stages advance together while the output register is empty or being taken.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset.
// Top level: segment versus box clip, entry point and entry parameter.
`timescale 1ns / 1ps
module segment_box_clip_entry #(
	parameter int FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sbce_in_if.sink    in_ch,
	sbce_out_if.source out_ch
);
	localparam int FB = FRACTION_BITS;
	localparam int QW = FB + 2;
	localparam int NE = sbce_pkg::NumEdges;

	// global advance, driven from the output register
	logic en;
	assign in_ch.ready = en;

	// widen inputs so no intermediate overflows
	logic signed [33:0] ex0, ey0, ex1, ey1, ecx, ecy, ehw, ehh;
	logic signed [33:0] dxc, dyc;
	logic signed [33:0] pc [NE];
	logic signed [33:0] qc [NE];

	assign ex0 = 34'(signed'(in_ch.start_x));
	assign ey0 = 34'(signed'(in_ch.start_y));
	assign ex1 = 34'(signed'(in_ch.end_x));
	assign ey1 = 34'(signed'(in_ch.end_y));
	assign ecx = 34'(signed'(in_ch.box_center_x));
	assign ecy = 34'(signed'(in_ch.box_center_y));
	assign ehw = {3'b000, in_ch.box_half_width};
	assign ehh = {3'b000, in_ch.box_half_height};
	assign dxc = ex1 - ex0;
	assign dyc = ey1 - ey0;

	// left, right, bottom, top
	assign pc[0] = -dxc;
	assign qc[0] = ex0 - ecx + ehw;
	assign pc[1] = dxc;
	assign qc[1] = ecx + ehw - ex0;
	assign pc[2] = -dyc;
	assign qc[2] = ey0 - ecy + ehh;
	assign pc[3] = dyc;
	assign qc[3] = ecy + ehh - ey0;

	logic               vld_s1, vld_s2;
	logic signed [31:0] x0_s1, y0_s1;
	logic signed [33:0] dx_s1, dy_s1;
	logic signed [33:0] p_s1 [NE];
	logic signed [33:0] q_s1 [NE];

	// stage 1: form p and q
	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= signed'(in_ch.start_x);
			y0_s1 <= signed'(in_ch.start_y);
			dx_s1 <= dxc;
			dy_s1 <= dyc;
			for (int e = 0; e < NE; e++) begin
				p_s1[e] <= pc[e];
				q_s1[e] <= qc[e];
			end
		end
	end

	// stage 2: magnitudes and edge flags for the divider lanes
	logic [33:0]      pm_s2 [NE];
	logic [33:0]      qm_s2 [NE];
	sbce_pkg::side_t  side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.x0 <= x0_s1;
			side_s2.y0 <= y0_s1;
			side_s2.dx <= dx_s1;
			side_s2.dy <= dy_s1;
			for (int e = 0; e < NE; e++) begin
				pm_s2[e] <= p_s1[e][33] ? 34'(-p_s1[e]) : p_s1[e];
				qm_s2[e] <= q_s1[e][33] ? 34'(-q_s1[e]) : q_s1[e];
				side_s2.edges[e].par   <= (p_s1[e] == '0);
				side_s2.edges[e].qneg  <= q_s1[e][33];
				side_s2.edges[e].pneg  <= p_s1[e][33];
				side_s2.edges[e].sdiff <= p_s1[e][33] ^ q_s1[e][33];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
		end
	end

	// one divider lane per edge
	logic [QW-1:0] quo [NE];

	for (genvar e = 0; e < NE; e++) begin : g_lane
		sbce_div #(.FB(FB)) u_div (
			.clk (clk),
			.en  (en),
			.num (qm_s2[e]),
			.den (pm_s2[e]),
			.quo (quo[e])
		);
	end

	// hold segment data and valid alongside the divider stages
	sbce_pkg::side_t side_d [QW];
	logic            vld_d  [QW];

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s2;
			for (int k = 1; k < QW; k++) side_d[k] <= side_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) vld_d[k] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld_s2;
			for (int k = 1; k < QW; k++) vld_d[k] <= vld_d[k-1];
		end
	end

	// combine, multiply, saturate and drive the output word
	sbce_point #(.FB(FB)) u_point (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_d[QW-1]),
		.side   (side_d[QW-1]),
		.quo    (quo),
		.en     (en),
		.out_ch (out_ch)
	);

endmodule
